// File: sv/ddo_pkg.sv
// Shared types, constants and helper functions of the odometry integrator.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int AW   = 48;
  localparam int BW   = 40;
  localparam int PW   = AW + BW;
  localparam int DW   = 8;
  localparam int NDIG = BW / DW;
  localparam int CW   = $clog2(NDIG);
  localparam int ZW   = 34;
  localparam int NITER = 30;
  localparam int IW   = $clog2(NITER);

  localparam logic signed [ZW-1:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [31:0]   PI_Q28       = 32'sd843314857;
  localparam logic signed [31:0]   TWO_PI_Q28   = 32'sd1686629713;

  localparam logic [23:0] C2D_RST  = 24'd25988;
  localparam logic [15:0] LG_RST   = 16'd17789;
  localparam logic [15:0] AG_RST   = 16'd16138;
  localparam logic [15:0] ITW_RST  = 16'd14322;
  localparam logic [9:0]  RATE_RST = 10'd50;

  typedef enum logic [2:0] {
    REG_C2D  = 3'd0,
    REG_LG   = 3'd1,
    REG_AG   = 3'd2,
    REG_ITW  = 3'd3,
    REG_RATE = 3'd4
  } cfg_reg_e;

  function automatic logic [ZW-1:0] atan_q30(input logic [IW-1:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0:  r = 34'h03243F6A8;
      5'd1:  r = 34'h01DAC6705;
      5'd2:  r = 34'h00FADBAFC;
      5'd3:  r = 34'h007F56EA6;
      5'd4:  r = 34'h003FEAB76;
      5'd5:  r = 34'h001FFD55B;
      5'd6:  r = 34'h000FFFAAA;
      5'd7:  r = 34'h0007FFF55;
      5'd8:  r = 34'h0003FFFEA;
      5'd9:  r = 34'h0001FFFFD;
      5'd10: r = 34'h0000FFFFF;
      5'd11: r = 34'h00007FFFF;
      5'd12: r = 34'h00003FFFF;
      5'd13: r = 34'h00001FFFF;
      5'd14: r = 34'h00000FFFF;
      5'd15: r = 34'h000007FFF;
      5'd16: r = 34'h000003FFF;
      5'd17: r = 34'h000001FFF;
      5'd18: r = 34'h000000FFF;
      5'd19: r = 34'h0000007FF;
      5'd20: r = 34'h0000003FF;
      5'd21: r = 34'h0000001FF;
      5'd22: r = 34'h0000000FF;
      5'd23: r = 34'h00000007F;
      5'd24: r = 34'h00000003F;
      5'd25: r = 34'h00000001F;
      5'd26: r = 34'h00000000F;
      5'd27: r = 34'h000000008;
      5'd28: r = 34'h000000004;
      5'd29: r = 34'h000000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [PW-1:0] round_sh(input logic signed [PW-1:0] v,
                                                    input int unsigned n);
    logic signed [PW-1:0] bias;
    bias = PW'(1) << (n - 1);
    return (v + bias) >>> n;
  endfunction

endpackage

// File: sv/differential_drive_odometry.sv
// Differential-drive odometry integrator with a shared multiplier and an iterative CORDIC.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | left_count_i, right_count_i
//  out     | output    | out_valid_o / out_ready_i| pos_x_o .. vel_heading_o
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One beat runs ten products on the shared multiplier, thirty CORDIC rotations at
// one per cycle, and a final load.
// Reset clears the pose to zero and loads the default register values.
// The input is taken only while the sequencer is idle; a finished pose waits in the
// output registers, and the next beat stalls only at its final load if it is not taken.
`timescale 1ns / 1ps
module differential_drive_odometry (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] left_count_i,
  input  logic signed [14:0] right_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic signed [30:0] heading_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_heading_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);
  import ddo_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CORDIC, S_OUT} state_e;
  typedef enum logic [3:0] {
    ST_SUM, ST_DIFF, ST_TRAVEL, ST_U, ST_W, ST_DX, ST_DY, ST_VX, ST_VY, ST_VH
  } step_e;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return v[47:0];
  endfunction

  function automatic logic signed [30:0] sat31(input logic signed [42:0] v);
    if (!((&v[42:30]) || !(|v[42:30]))) return v[42] ? {1'b1, 30'b0} : {1'b0, {30{1'b1}}};
    return v[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (!((&v[PW-1:31]) || !(|v[PW-1:31]))) begin
      return v[PW-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
    return v[31:0];
  endfunction

  state_e state_q;
  step_e  step_q;

  logic [23:0] c2d_q;
  logic [15:0] lg_q, ag_q, itw_q;
  logic [9:0]  rate_q;

  logic signed [14:0] left_q, right_q;
  logic signed [39:0] sum_q, diff_q, u_q;
  logic signed [40:0] travel_q;
  logic signed [41:0] w_q, dx_q, dy_q;
  logic signed [31:0] vx_q, vy_q, vh_q;
  logic signed [47:0] x_q, y_q;
  logic signed [30:0] heading_q;

  logic signed [ZW-1:0] cx_q, cy_q, cz_q;
  logic                 flip_q;
  logic [IW-1:0]        iter_q;

  logic                 out_valid_q;
  logic signed [47:0]   pos_x_q, pos_y_q;
  logic signed [30:0]   head_out_q;
  logic signed [31:0]   vel_x_q, vel_y_q, vel_h_q;

  logic                 mul_start, mul_done;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] rnd12, rnd14, rnd15, rnd16, rnd30;

  logic signed [15:0]   lr_sum, lr_diff;
  logic signed [ZW-1:0] cos_v, sin_v, tx, ty, atan_v, z_init;
  logic signed [42:0]   head_sum;
  logic signed [31:0]   head_sat, head_wrap;

  always_comb begin
    lr_sum  = 16'(left_q) + 16'(right_q);
    lr_diff = 16'(right_q) - 16'(left_q);
    cos_v   = flip_q ? -cx_q : cx_q;
    sin_v   = flip_q ? -cy_q : cy_q;
    tx      = cy_q >>> iter_q;
    ty      = cx_q >>> iter_q;
    atan_v  = $signed(atan_q30(iter_q));
    z_init  = {heading_q[30], heading_q, 2'b00};
    rnd12   = round_sh(mul_p, 12);
    rnd14   = round_sh(mul_p, 14);
    rnd15   = round_sh(mul_p, 15);
    rnd16   = round_sh(mul_p, 16);
    rnd30   = round_sh(mul_p, 30);
    head_sum = 43'(heading_q) + 43'(w_q);
    head_sat = 32'(sat31(head_sum));
    if (head_sat > PI_Q28) begin
      head_wrap = head_sat - TWO_PI_Q28;
    end else if (head_sat < -PI_Q28) begin
      head_wrap = head_sat + TWO_PI_Q28;
    end else begin
      head_wrap = head_sat;
    end
  end

  always_comb begin
    mul_a = AW'(c2d_q);
    mul_b = BW'(lr_sum);
    case (step_q)
      ST_SUM:    begin mul_a = AW'(c2d_q);   mul_b = BW'(lr_sum);  end
      ST_DIFF:   begin mul_a = AW'(c2d_q);   mul_b = BW'(lr_diff); end
      ST_TRAVEL: begin mul_a = AW'(sum_q);   mul_b = BW'(lg_q);    end
      ST_U:      begin mul_a = AW'(diff_q);  mul_b = BW'(itw_q);   end
      ST_W:      begin mul_a = AW'(u_q);     mul_b = BW'(ag_q);    end
      ST_DX:     begin mul_a = AW'(travel_q); mul_b = BW'(cos_v);  end
      ST_DY:     begin mul_a = AW'(travel_q); mul_b = BW'(sin_v);  end
      ST_VX:     begin mul_a = AW'(dx_q);    mul_b = BW'(rate_q);  end
      ST_VY:     begin mul_a = AW'(dy_q);    mul_b = BW'(rate_q);  end
      ST_VH:     begin mul_a = AW'(w_q);     mul_b = BW'(rate_q);  end
      default:   begin mul_a = AW'(c2d_q);   mul_b = BW'(lr_sum);  end
    endcase
  end

  assign mul_start = (state_q == S_ISSUE);

  ddo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2d_q  <= C2D_RST;
      lg_q   <= LG_RST;
      ag_q   <= AG_RST;
      itw_q  <= ITW_RST;
      rate_q <= RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_C2D:  c2d_q  <= cfg_data_i;
        REG_LG:   lg_q   <= cfg_data_i[15:0];
        REG_AG:   ag_q   <= cfg_data_i[15:0];
        REG_ITW:  itw_q  <= cfg_data_i[15:0];
        REG_RATE: rate_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_SUM;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      heading_q   <= '0;
      iter_q      <= '0;
      flip_q      <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      sum_q       <= '0;
      diff_q      <= '0;
      u_q         <= '0;
      travel_q    <= '0;
      w_q         <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vh_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_out_q  <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      vel_h_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            left_q  <= left_count_i;
            right_q <= right_count_i;
            step_q  <= ST_SUM;
            state_q <= S_ISSUE;
            iter_q  <= '0;
            cx_q    <= CORDIC_K_Q30;
            cy_q    <= '0;
            if (z_init > HALF_PI_Q30) begin
              cz_q   <= z_init - PI_Q30;
              flip_q <= 1'b1;
            end else if (z_init < -HALF_PI_Q30) begin
              cz_q   <= z_init + PI_Q30;
              flip_q <= 1'b1;
            end else begin
              cz_q   <= z_init;
              flip_q <= 1'b0;
            end
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            state_q <= S_ISSUE;
            case (step_q)
              ST_SUM:    begin sum_q  <= mul_p[39:0]; step_q <= ST_DIFF; end
              ST_DIFF:   begin diff_q <= mul_p[39:0]; step_q <= ST_TRAVEL; end
              ST_TRAVEL: begin travel_q <= rnd15[40:0]; step_q <= ST_U; end
              ST_U:      begin u_q <= rnd16[39:0]; step_q <= ST_W; end
              ST_W: begin
                w_q     <= rnd14[41:0];
                step_q  <= ST_DX;
                state_q <= S_CORDIC;
              end
              ST_DX: begin
                dx_q   <= rnd30[41:0];
                x_q    <= sat48(49'(x_q) + 49'(rnd30));
                step_q <= ST_DY;
              end
              ST_DY: begin
                dy_q   <= rnd30[41:0];
                y_q    <= sat48(49'(y_q) + 49'(rnd30));
                step_q <= ST_VX;
              end
              ST_VX: begin vx_q <= sat32(rnd16); step_q <= ST_VY; end
              ST_VY: begin vy_q <= sat32(rnd16); step_q <= ST_VH; end
              ST_VH: begin
                vh_q      <= sat32(rnd12);
                heading_q <= head_wrap[30:0];
                state_q   <= S_OUT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_CORDIC: begin
          if (!cz_q[ZW-1]) begin
            cx_q <= cx_q - tx;
            cy_q <= cy_q + ty;
            cz_q <= cz_q - atan_v;
          end else begin
            cx_q <= cx_q + tx;
            cy_q <= cy_q - ty;
            cz_q <= cz_q + atan_v;
          end
          iter_q <= iter_q + 1'b1;
          if (iter_q == IW'(NITER - 1)) state_q <= S_ISSUE;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            pos_x_q     <= x_q;
            pos_y_q     <= y_q;
            head_out_q  <= heading_q;
            vel_x_q     <= vx_q;
            vel_y_q     <= vy_q;
            vel_h_q     <= vh_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign heading_o     = head_out_q;
  assign vel_x_o       = vel_x_q;
  assign vel_y_o       = vel_y_q;
  assign vel_heading_o = vel_h_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_ISSUE))
    else $error("accepted beat did not start the sequence");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_WAIT)) else $error("product arrived outside wait");
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (heading_q == $past(head_wrap[30:0]) || $stable(heading_q)))
    else $error("heading changed outside its update");
`endif

endmodule

// File: sv/ddo_mul.sv
// Shared signed multiplier that consumes one byte of the second operand per cycle.
`timescale 1ns / 1ps
module ddo_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ddo_pkg::AW-1:0]    a_i,
  input  logic signed [ddo_pkg::BW-1:0]    b_i,
  output logic                             done_o,
  output logic signed [ddo_pkg::PW-1:0]    p_o
);
  import ddo_pkg::*;

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [AW-1:0] a_q;
  logic [BW-1:0]        b_q;
  logic signed [PW-1:0] acc_q;
  logic signed [DW:0]   digit;
  logic signed [AW+DW:0] part;

  always_comb begin
    if (cnt_q == '0) begin
      digit = {b_q[BW-1], b_q[BW-1 -: DW]};
    end else begin
      digit = {1'b0, b_q[BW-1 -: DW]};
    end
    part = a_q * digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NDIG - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= b_q << DW;
      acc_q <= (acc_q <<< DW) + PW'(part);
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiplier started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while still busy");
`endif

endmodule
